[design/tli_pkg.sv]
`default_nettype none
package tli_pkg;
  localparam int unsigned TableDepth = 512;
  localparam int unsigned CountW = 10;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] StInterp = 2'd0;
  localparam logic [1:0] StLow = 2'd1;
  localparam logic [1:0] StHigh = 2'd2;
  localparam logic [1:0] StZero = 2'd3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CHK_FIRST,
    S_RD_LAST,
    S_CHK_LAST,
    S_RD_MID,
    S_CHK_MID,
    S_RD_LO,
    S_RD_HI,
    S_PREP,
    S_MUL,
    S_DIV,
    S_OUT
  } tli_state_e;
endpackage
`default_nettype wire

[design/tli_mul.sv]
`default_nettype none
// Shift-add multiplier: one multiplier bit per cycle.
module tli_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);
  logic [63:0] acc_q, acc_d;
  logic [63:0] mcand_q, mcand_d;
  logic [31:0] mplier_q, mplier_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  always_comb begin
    acc_d = acc_q;
    mcand_d = mcand_q;
    mplier_d = mplier_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d = '0;
      mcand_d = {32'd0, a_i};
      mplier_d = b_i;
      cnt_d = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d = {mcand_q[62:0], 1'b0};
      mplier_d = {1'b0, mplier_q[31:1]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mcand_q <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd31) && !start_i;
  assign prod_o = acc_d;
endmodule
`default_nettype wire

[design/tli_div.sv]
`default_nettype none
// Restoring divider, 64 by 32, one quotient bit per cycle.
module tli_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[31:0], quo_q[63]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd63) && !start_i;
  assign quo_o = quo_d;
endmodule
`default_nettype wire

[design/table_linear_interpolator.sv]
`default_nettype none
// Piecewise-linear table interpolator.
// Input channel (in_valid_i/in_ready_o): opcode 0 loads breakpoint and value
// at entry_index, opcode 1 queries at wavelength. Loads give no result word;
// queries give one word on the output channel (out_valid_o/out_ready_i).
// Config channel (cfg_valid_i/cfg_ready_o) writes entries_in_use; write it
// only while the block is idle.
// One word at a time. A query clamped low gives its result after reading
// entry 0, one clamped high after also reading the last entry in use, and an
// interpolated one after a binary search whose reads use the single table
// port, then a bit-serial multiply and a bit-serial divide (a bracket whose
// breakpoints do not rise gives zero instead). The next word is accepted in
// the cycle after the result is taken.
// The result is held in the output register until taken; the input stays
// blocked while it waits. Reset clears the control state and sets
// entries_in_use to 512; table contents are undefined until loaded.
module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::TableDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        opcode_i,
  input  wire logic [8:0]                  entry_index_i,
  input  wire logic [31:0]                 wavelength_i,
  input  wire logic [31:0]                 sample_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [31:0]                      interpolated_value_o,
  output logic [1:0]                       status_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tli_pkg::CountW-1:0]  cfg_data_i
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = AW + 1;

  logic [63:0] mem_q [TABLE_DEPTH];
  logic [63:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  tli_pkg::tli_state_e state_q, state_d;
  logic [tli_pkg::CountW-1:0] cnt_cfg_q;
  logic [NW-1:0] n_used;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, mid;
  logic [31:0] q_q, bl_q, vl_q, base_q, den_q;
  logic [31:0] mul_a, mul_b;
  logic [31:0] res_q, res_d;
  logic [1:0]  st_q, st_d;
  logic        out_v_q;
  logic [31:0] bh, vh;

  logic mul_start, mul_done, div_start, div_done;
  logic [63:0] prod, quo;

  // Clamp the count to 1..TABLE_DEPTH
  always_comb begin
    if (cnt_cfg_q == '0) begin
      n_used = NW'(1);
    end else if (32'(cnt_cfg_q) > TABLE_DEPTH) begin
      n_used = NW'(TABLE_DEPTH);
    end else begin
      n_used = NW'(cnt_cfg_q);
    end
  end

  assign mid = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign bh = rd_q[63:32];
  assign vh = rd_q[31:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      tli_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o && opcode_i == tli_pkg::OpQuery) begin
          state_d = tli_pkg::S_RD_FIRST;
        end
      end
      tli_pkg::S_RD_FIRST: state_d = tli_pkg::S_CHK_FIRST;
      tli_pkg::S_CHK_FIRST: begin
        state_d = (q_q <= bh) ? tli_pkg::S_OUT : tli_pkg::S_RD_LAST;
      end
      tli_pkg::S_RD_LAST: state_d = tli_pkg::S_CHK_LAST;
      tli_pkg::S_CHK_LAST: begin
        if (q_q >= bh) begin
          state_d = tli_pkg::S_OUT;
        end else if (hi_q - lo_q > AW'(1)) begin
          state_d = tli_pkg::S_RD_MID;
        end else begin
          state_d = tli_pkg::S_RD_LO;
        end
      end
      tli_pkg::S_RD_MID: state_d = tli_pkg::S_CHK_MID;
      tli_pkg::S_CHK_MID: begin
        state_d = (hi_d - lo_d > AW'(1)) ? tli_pkg::S_RD_MID : tli_pkg::S_RD_LO;
      end
      tli_pkg::S_RD_LO: state_d = tli_pkg::S_RD_HI;
      tli_pkg::S_RD_HI: state_d = tli_pkg::S_PREP;
      tli_pkg::S_PREP: begin
        state_d = (bh <= bl_q) ? tli_pkg::S_OUT : tli_pkg::S_MUL;
      end
      tli_pkg::S_MUL: state_d = mul_done ? tli_pkg::S_DIV : tli_pkg::S_MUL;
      tli_pkg::S_DIV: state_d = div_done ? tli_pkg::S_OUT : tli_pkg::S_DIV;
      tli_pkg::S_OUT: state_d = (out_v_q && out_ready_i) ? tli_pkg::S_IDLE : tli_pkg::S_OUT;
      default: state_d = tli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    lo_d = lo_q;
    hi_d = hi_q;
    res_d = res_q;
    st_d = st_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      tli_pkg::S_IDLE: begin
        lo_d = '0;
        hi_d = AW'(n_used - NW'(1));
      end
      tli_pkg::S_RD_FIRST: begin
        rd_en = 1'b1;
        rd_addr = '0;
      end
      tli_pkg::S_CHK_FIRST: begin
        res_d = vh;
        st_d = tli_pkg::StLow;
      end
      tli_pkg::S_RD_LAST: begin
        rd_en = 1'b1;
        rd_addr = hi_q;
      end
      tli_pkg::S_CHK_LAST: begin
        res_d = vh;
        st_d = tli_pkg::StHigh;
      end
      tli_pkg::S_RD_MID: begin
        rd_en = 1'b1;
        rd_addr = mid;
      end
      tli_pkg::S_CHK_MID: begin
        if (q_q >= bh) begin
          lo_d = mid;
        end else begin
          hi_d = mid;
        end
      end
      tli_pkg::S_RD_LO: begin
        rd_en = 1'b1;
        rd_addr = lo_q;
      end
      tli_pkg::S_RD_HI: begin
        rd_en = 1'b1;
        rd_addr = hi_q;
      end
      tli_pkg::S_PREP: begin
        res_d = '0;
        st_d = tli_pkg::StZero;
        if (bh > bl_q) begin
          mul_start = 1'b1;
          st_d = tli_pkg::StInterp;
        end
      end
      tli_pkg::S_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
        end
      end
      tli_pkg::S_DIV: begin
        if (div_done) begin
          res_d = base_q + quo[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Multiplier operands in S_PREP: rd_q holds hi, bl_q/vl_q hold lo
  always_comb begin
    if (vh >= vl_q) begin
      mul_a = vh - vl_q;
      mul_b = q_q - bl_q;
    end else begin
      mul_a = vl_q - vh;
      mul_b = bh - q_q;
    end
  end

  tli_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && opcode_i == tli_pkg::OpLoad &&
        {23'd0, entry_index_i} < 32'(TABLE_DEPTH)) begin
      mem_q[AW'(entry_index_i)] <= {wavelength_i, sample_value_i};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      q_q <= wavelength_i;
    end
    if (state_q == tli_pkg::S_RD_HI) begin
      bl_q <= rd_q[63:32];
      vl_q <= rd_q[31:0];
    end
    if (state_q == tli_pkg::S_PREP) begin
      base_q <= (vh >= vl_q) ? vl_q : vh;
      den_q <= bh - bl_q;
    end
    res_q <= res_d;
    st_q <= st_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tli_pkg::S_IDLE;
      cnt_cfg_q <= tli_pkg::CountW'(512);
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_cfg_q <= cfg_data_i;
      end
      if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end else if (state_q != tli_pkg::S_OUT && state_d == tli_pkg::S_OUT) begin
        out_v_q <= 1'b1;
      end
    end
  end

  assign in_ready_o = (state_q == tli_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign interpolated_value_o = res_q;
  assign status_o = st_q;

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> state_q == tli_pkg::S_OUT)
    else $error("result valid outside output state");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != tli_pkg::S_IDLE |-> !in_ready_o)
    else $error("input accepted while busy");
  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tli_pkg::S_RD_LO |-> hi_q - lo_q == AW'(1))
    else $error("bracket not adjacent");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> $stable(res_q) && $stable(st_q))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire
